FILE: sv/sacr_pkg.sv
`default_nettype none

package sacr_pkg;

    // Geometry limits of the storage.
    localparam int MAX_SETS     = 64;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 31;
    localparam int SET_BITS     = $clog2(MAX_SETS);
    localparam int WAY_BITS     = $clog2(MAX_WAYS);
    localparam int RANK_BITS    = WAY_BITS;
    localparam int TAG_IDX_BITS = SET_BITS + WAY_BITS;
    localparam int CNT_BITS     = 32;

    // Replacement policy codes. Code three behaves as FIFO.
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_MRU  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_WORDS  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;
    localparam logic [1:0] REG_SETS   = 2'd3;

    // Configuration as seen by the lookup engine; the set count is already clamped.
    typedef struct packed {
        logic [1:0] policy;
        logic [3:0] words_log2;
        logic [1:0] ways_log2;
        logic [2:0] sets_log2;
    } t_cfg;

    // Per-set replacement state, one row of the set memory.
    typedef struct packed {
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
        logic [WAY_BITS-1:0]                fill;
        logic                               full;
        logic                               armed;
        logic [WAY_BITS-1:0]                mru_way;
    } t_set_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Finished lookup handed from the engine to the output stage.
    typedef struct packed {
        logic                done;
        logic                hit;
        logic [WAY_BITS-1:0] way;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/sacr_engine.sv
`default_nettype none

module sacr_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sacr_pkg::t_cfg                   i_cfg,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [sacr_pkg::ADDR_BITS-1:0]   i_address,
    input  logic                             i_out_free,
    output sacr_pkg::t_result                o_result
);
    import sacr_pkg::*;

    // Tag store, indexed by set and way, and the per-set state rows.
    logic [ADDR_BITS-1:0]    tag_mem [MAX_SETS*MAX_WAYS];
    t_set_row                row_mem [MAX_SETS];
    logic [MAX_SETS-1:0]     r_row_ok;

    t_set_row                r_row_q;
    logic                    r_row_q_ok;
    logic [ADDR_BITS-1:0]    r_tag_q;

    t_state                  r_state, n_state;
    logic [ADDR_BITS-1:0]    r_blk, n_blk;
    logic [SET_BITS-1:0]     r_set, n_set;
    logic [WAY_BITS-1:0]     r_way, n_way;
    logic [WAY_BITS-1:0]     r_best, n_best;
    logic                    r_hit, n_hit;
    logic [WAY_BITS-1:0]     r_hit_way, n_hit_way;

    logic [WAY_BITS-1:0]     way_mask;
    logic [SET_BITS-1:0]     set_mask;
    logic [ADDR_BITS-1:0]    blk_in;
    logic [SET_BITS-1:0]     set_in;
    logic [TAG_IDX_BITS-1:0] tag_rd_addr;
    logic                    accept;
    logic                    commit;
    logic                    is_lru;
    logic                    is_mru;
    logic                    match;
    t_set_row                row;
    t_set_row                row_next;
    logic [WAY_BITS-1:0]     victim;
    logic [RANK_BITS-1:0]    old_rank;
    logic [WAY_BITS-1:0]     mru_now;

    // Geometry decode.
    assign way_mask = WAY_BITS'((4'd1 << i_cfg.ways_log2) - 4'd1);
    assign set_mask = SET_BITS'(((SET_BITS+1)'(1) << i_cfg.sets_log2) - (SET_BITS+1)'(1));
    assign blk_in   = i_address >> i_cfg.words_log2;
    assign set_in   = SET_BITS'(blk_in) & set_mask;
    assign is_lru   = (i_cfg.policy == POL_LRU);
    assign is_mru   = (i_cfg.policy == POL_MRU);

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign commit      = (r_state == ST_DONE) && i_out_free;

    // A set row that was never written reads as all zero.
    assign row   = r_row_q_ok ? r_row_q : '0;
    assign match = row.valid[r_way] && (r_tag_q == r_blk);

    // Way 0 is fetched with the request, later ways one per scan cycle.
    assign tag_rd_addr = (r_state == ST_IDLE) ? {set_in, WAY_BITS'(0)}
                                              : {r_set, r_way + WAY_BITS'(1)};

    // Tag store: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        r_tag_q <= tag_mem[tag_rd_addr];
        if (commit && !r_hit) begin
            tag_mem[{r_set, victim}] <= r_blk;
        end
    end

    // Set state store, read at request time and written back at commit.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_q    <= row_mem[set_in];
            r_row_q_ok <= r_row_ok[set_in];
        end
        if (commit) begin
            row_mem[r_set] <= row_next;
        end
    end

    // Row valid bits stand in for the cleared state after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (commit) begin
            r_row_ok[r_set] <= 1'b1;
        end
    end

    // Victim choice and the new replacement state of the set.
    always_comb begin
        row_next = row;
        victim   = r_hit_way;
        old_rank = way_mask;
        mru_now  = row.mru_way;
        if (is_mru && row.full && !row.armed) begin
            row_next.armed = 1'b1;
            mru_now        = way_mask;
        end
        if (r_hit) begin
            victim   = r_hit_way;
            old_rank = row.rank[r_hit_way];
            if (is_mru && row.full) begin
                mru_now = r_hit_way;
            end
        end else begin
            if (row.full && is_lru) begin
                victim = r_best;
            end else if (row.full && is_mru) begin
                victim = mru_now & way_mask;
            end else begin
                victim        = row.fill & way_mask;
                row_next.fill = (victim + WAY_BITS'(1)) & way_mask;
                if (victim == way_mask) begin
                    row_next.full = 1'b1;
                end
            end
            row_next.valid[victim] = 1'b1;
        end
        row_next.mru_way = mru_now;
        if (is_lru) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                if ((WAY_BITS'(i) <= way_mask) && (WAY_BITS'(i) != victim) &&
                    (row.rank[i] < old_rank)) begin
                    row_next.rank[i] = row.rank[i] + RANK_BITS'(1);
                end
            end
            row_next.rank[victim] = '0;
        end
    end

    // Sequencer: scan the ways with one shared comparator.
    always_comb begin
        n_state   = r_state;
        n_blk     = r_blk;
        n_set     = r_set;
        n_way     = r_way;
        n_best    = r_best;
        n_hit     = r_hit;
        n_hit_way = r_hit_way;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state   = ST_SCAN;
                    n_blk     = blk_in;
                    n_set     = set_in;
                    n_way     = '0;
                    n_best    = '0;
                    n_hit     = 1'b0;
                    n_hit_way = '0;
                end
            end
            ST_SCAN: begin
                if (row.rank[r_way] > row.rank[r_best]) begin
                    n_best = r_way;
                end
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_way = r_way;
                    n_state   = ST_DONE;
                end else if (r_way == way_mask) begin
                    n_state = ST_DONE;
                end else begin
                    n_way = r_way + WAY_BITS'(1);
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk     <= n_blk;
        r_set     <= n_set;
        r_way     <= n_way;
        r_best    <= n_best;
        r_hit     <= n_hit;
        r_hit_way <= n_hit_way;
    end

    assign o_result.done = commit;
    assign o_result.hit  = r_hit;
    assign o_result.way  = victim;

endmodule

`default_nettype wire

FILE: sv/set_assoc_cache_replacement_unit.sv
// Set-associative cache replacement unit with FIFO, LRU and MRU policies.
// The input channel (i_valid, o_ready, i_address) carries one word address
// per request. The output channel (o_valid, i_ready) returns hit or miss,
// the way that hit or was filled, and the saturating hit and miss counts
// after that access. The APB port sets the policy and the geometry; write
// it only while no request is in flight.
// A request scans the ways of its set from way 0 and stops at the first hit
// or after the last way. The ways of the set are compared one per cycle by a
// single tag comparator, so the unit takes one request at a time and is ready
// again in the same cycle that its result appears in the output register.
// Reset clears the configuration, the counters and the per-set valid bits,
// so every set reads as empty at once; no clearing pass is needed.
// A finished result sits in the output register; if the receiver stalls, the
// next request may still be accepted and is held at its final step until
// the output register frees.
`default_nettype none

module set_assoc_cache_replacement_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sacr_pkg::ADDR_BITS-1:0] i_address,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic [2:0]                     o_way_used,
    output logic [sacr_pkg::CNT_BITS-1:0]  o_hit_total,
    output logic [sacr_pkg::CNT_BITS-1:0]  o_miss_total,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sacr_pkg::*;

    logic [1:0]          r_policy;
    logic [3:0]          r_words_log2;
    logic [1:0]          r_ways_log2;
    logic [2:0]          r_sets_log2;
    logic [CNT_BITS-1:0] r_hit_cnt;
    logic [CNT_BITS-1:0] r_miss_cnt;
    logic                r_out_valid;
    logic                r_out_hit;
    logic [2:0]          r_out_way;

    logic                cfg_write;
    logic [1:0]          reg_idx;
    logic                out_free;
    t_cfg                cfg;
    t_result             result;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIFO;
            r_words_log2 <= '0;
            r_ways_log2  <= '0;
            r_sets_log2  <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_POLICY: r_policy     <= pwdata[1:0];
                REG_WORDS:  r_words_log2 <= pwdata[3:0];
                REG_WAYS:   r_ways_log2  <= pwdata[1:0];
                REG_SETS:   r_sets_log2  <= pwdata[2:0];
                default:    r_policy     <= r_policy;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_idx)
            REG_POLICY: prdata = {30'd0, r_policy};
            REG_WORDS:  prdata = {28'd0, r_words_log2};
            REG_WAYS:   prdata = {30'd0, r_ways_log2};
            REG_SETS:   prdata = {29'd0, r_sets_log2};
            default:    prdata = '0;
        endcase
    end

    // Set counts beyond the storage fold down to the largest one.
    always_comb begin
        cfg.policy     = r_policy;
        cfg.words_log2 = r_words_log2;
        cfg.ways_log2  = r_ways_log2;
        cfg.sets_log2  = (r_sets_log2 > 3'(SET_BITS)) ? 3'(SET_BITS) : r_sets_log2;
    end

    assign out_free = !r_out_valid || i_ready;

    sacr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_address   (i_address),
        .i_out_free  (out_free),
        .o_result    (result)
    );

    // Saturating hit and miss counters, updated as each result is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (result.done) begin
            if (result.hit && (r_hit_cnt != '1)) begin
                r_hit_cnt <= r_hit_cnt + CNT_BITS'(1);
            end
            if (!result.hit && (r_miss_cnt != '1)) begin
                r_miss_cnt <= r_miss_cnt + CNT_BITS'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.done) begin
            r_out_hit <= result.hit;
            r_out_way <= 3'(result.way);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_way_used   = r_out_way;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

endmodule

`default_nettype wire

FILE: sv/sacr_checker.sv
`default_nettype none

module sacr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_out_hit,
    input  logic [2:0]                    i_out_way,
    input  logic [sacr_pkg::CNT_BITS-1:0] i_hit_total,
    input  logic [sacr_pkg::CNT_BITS-1:0] i_miss_total
);
    import sacr_pkg::*;

    // A stalled result keeps its fields.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit) &&
        $stable(i_out_way))
        else $error("result changed while stalled");

    // The counts never move while a result waits to be taken.
    a_stall_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_hit_total) && $stable(i_miss_total))
        else $error("counts changed while result stalled");

    // Counts only grow between resets.
    a_counts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (i_hit_total >= $past(i_hit_total)) &&
        (i_miss_total >= $past(i_miss_total)))
        else $error("count decreased");

    // A shown hit or miss is already included in its count.
    a_count_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_hit && (i_hit_total != '0)) ||
        (!i_out_hit && (i_miss_total != '0)))
        else $error("result not reflected in counts");

    // The unit is busy in the cycle after it accepts a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after accepting a request");

endmodule

bind set_assoc_cache_replacement_unit sacr_checker u_sacr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_valid),
    .i_req_ready  (o_ready),
    .i_out_valid  (o_valid),
    .i_out_ready  (i_ready),
    .i_out_hit    (o_hit),
    .i_out_way    (o_way_used),
    .i_hit_total  (o_hit_total),
    .i_miss_total (o_miss_total)
);

`default_nettype wire
